FILE: src/ettv_pkg.sv
// shared constants, types and calibration table for the echo time to tank volume block
package ettv_pkg;

    // field widths
    localparam int ECHO_W    = 16;
    localparam int SUM_W     = 19;
    localparam int CNT_W     = 3;
    localparam int TANK_W    = 10;
    localparam int LIT_W     = 11;
    localparam int GALW_W    = 9;
    localparam int TENTH_W   = 4;
    localparam int PCT_W     = 7;

    // averaging
    localparam int AVG_SAMPLES  = 5;
    localparam int RECIP_SHIFT  = 22;
    localparam int RECIP_W      = 23;
    localparam int AVG_RECIP    = (2 ** RECIP_SHIFT + AVG_SAMPLES - 1) / AVG_SAMPLES;
    localparam int PROD_W       = SUM_W + RECIP_W;

    // calibration table
    localparam int CAL_POINTS       = 12;
    localparam int ROM_SLOTS        = 32;
    localparam int ROM_AW           = 5;
    localparam int CAL_W            = 13;
    localparam int LITERS_PER_POINT = 100;

    // gallons
    localparam int GAL_MUL     = 541;
    localparam int GAL_MUL_W   = 10;
    localparam int GAL_SHIFT   = 6;
    localparam int GAL_FRAC_W  = 5;
    localparam int GAL_PROD_W  = LIT_W + GAL_MUL_W;
    localparam int TENTH_MUL   = 10;
    localparam int TENTH_PW    = GAL_FRAC_W + TENTH_W;

    // percent
    localparam int PCT_MUL          = 50;
    localparam int PCT_DIV          = 5;
    localparam int PCT_RECIP        = (2 ** RECIP_SHIFT + PCT_DIV - 1) / PCT_DIV;
    localparam int PCT_MAX          = 127;
    localparam int TANK_RESET       = 1000;
    localparam int TANK_RECIP       = 205;
    localparam int TANK_RECIP_W     = 8;
    localparam int TANK_RECIP_SHIFT = 11;
    localparam int TANK_PROD_W      = TANK_W + TANK_RECIP_W;
    localparam int TDIV_W           = 7;

    // shared divider
    localparam int DIVD_W    = 20;
    localparam int DIVS_W    = 13;
    localparam int DIV_CNT_W = 5;

    // state memory
    localparam int STATE_W     = SUM_W + CNT_W;
    localparam int STATE_DEPTH = 1;
    localparam int STATE_AW    = 1;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } state_word_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    // echo time in microseconds at each 100 liter point, descending
    localparam logic [CAL_W-1:0] CAL_ROM [ROM_SLOTS] = '{
        13'd5960, 13'd5380, 13'd4800, 13'd4240, 13'd3734, 13'd3200,
        13'd2684, 13'd2150, 13'd1612, 13'd1068, 13'd536,  13'd4,
        13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0,
        13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0,
        13'd0, 13'd0, 13'd0, 13'd0
    };

    function automatic logic [CAL_W-1:0] cal_point(input logic [ROM_AW-1:0] idx);
        return CAL_ROM[idx];
    endfunction

endpackage

FILE: src/ettv_ram.sv
// generic single-port-write ram with registered read
module ettv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ettv_div.sv
// restoring divider, one quotient bit per cycle
module ettv_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ettv_pkg::div_req_t req,
    output ettv_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [ettv_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ettv_pkg::DIVD_W-1:0]    quo_reg, quo_next;
    logic [ettv_pkg::DIVS_W-1:0]    rem_reg, rem_next;
    logic [ettv_pkg::DIVS_W-1:0]    dvs_reg, dvs_next;
    logic [ettv_pkg::DIVS_W:0]      trial;
    logic [ettv_pkg::DIVS_W:0]      diff;
    logic                           ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[ettv_pkg::DIVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ettv_pkg::DIV_CNT_W'(ettv_pkg::DIVD_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[ettv_pkg::DIVS_W-1:0] : trial[ettv_pkg::DIVS_W-1:0];
            quo_next = {quo_reg[ettv_pkg::DIVD_W-2:0], ge};
            cnt_next = cnt_reg - ettv_pkg::DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: src/echo_time_to_tank_volume.sv
// top level: echo averaging, calibration table walk, liters, gallons and percent full
//
// Echo time to tank volume. Each accepted item is one echo slot (echo_valid,
// echo_time in microseconds). Items with echo_valid low are taken and change
// nothing. A valid echo is added to a running sum and count that live in a
// one-entry state ram (read, modify, write back). Every fifth valid echo
// closes the batch: the sum is divided by five with a reciprocal multiply,
// the mean is walked down the 12-point calibration table one point per cycle,
// and the position inside the segment is found with a shared restoring
// divider (20 quotient bits). The same divider then forms liters*50 over
// tank_capacity/10 for percent full, which saturates at 127. Gallons come
// from liters*541>>6 with five fraction bits, reported as whole gallons and
// a tenths digit. echo_sum reports the batch sum.
// After reset the block clears the state ram and holds in_stall high
// meanwhile. Results sit in an output register, so the next item is taken
// while a result waits. tank_capacity is written through the cfg channel,
// always ready, and is meant to change only while the block is idle.
module echo_time_to_tank_volume (
    input  logic                           clk,
    input  logic                           rst_n,
    // input items
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           echo_valid,
    input  logic [ettv_pkg::ECHO_W-1:0]    echo_time,
    // result items
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ettv_pkg::LIT_W-1:0]     liters,
    output logic [ettv_pkg::GALW_W-1:0]    gallons_whole,
    output logic [ettv_pkg::TENTH_W-1:0]   gallons_tenth,
    output logic [ettv_pkg::PCT_W-1:0]     percent_full,
    output logic [ettv_pkg::SUM_W-1:0]     echo_sum,
    // tank size register
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ettv_pkg::TANK_W-1:0]    tank_capacity
);

    typedef enum logic [3:0] {
        S_INIT,     // clear the state ram
        S_IDLE,     // wait for an item
        S_READ,     // state word arrives, accumulate and write back
        S_MEAN,     // sum times reciprocal of five
        S_WALK0,    // mean ready, check against the first point
        S_WALK,     // step down the table
        S_INTERP,   // start the segment division
        S_WAIT_I,   // wait for the segment fraction
        S_CONV,     // liters = whole points plus fraction
        S_GAL,      // gallons product, start percent division
        S_WAIT_P,   // wait for percent quotient, scale by one fifth
        S_OUT       // load the output register
    } state_t;

    state_t                              state_reg, state_next;
    logic [ettv_pkg::ECHO_W-1:0]         time_reg, time_next;
    logic [ettv_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [ettv_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic [ettv_pkg::SUM_W-1:0]          mean_reg, mean_next;
    logic [ettv_pkg::ROM_AW-1:0]         idx_reg, idx_next;
    logic [ettv_pkg::LIT_W-1:0]          vol_reg, vol_next;
    logic [ettv_pkg::LIT_W-1:0]          part_reg, part_next;
    logic [ettv_pkg::LIT_W-1:0]          lit_reg, lit_next;
    logic [ettv_pkg::GAL_PROD_W-1:0]     gal_reg, gal_next;
    logic [ettv_pkg::TANK_W-1:0]         tank_reg, tank_next;
    logic                                out_valid_reg, out_valid_next;
    logic [ettv_pkg::LIT_W-1:0]          liters_reg, liters_next;
    logic [ettv_pkg::GALW_W-1:0]         galw_reg, galw_next;
    logic [ettv_pkg::TENTH_W-1:0]        tenth_reg, tenth_next;
    logic [ettv_pkg::PCT_W-1:0]          pct_reg, pct_next;
    logic [ettv_pkg::SUM_W-1:0]          esum_reg, esum_next;

    // state ram port
    logic                                ram_we;
    ettv_pkg::state_word_t               ram_wdata;
    ettv_pkg::state_word_t               ram_rdata;
    logic [ettv_pkg::STATE_W-1:0]        ram_rbits;

    // divider port
    ettv_pkg::div_req_t                  div_req;
    ettv_pkg::div_rsp_t                  div_rsp;

    // datapath helpers
    logic [ettv_pkg::SUM_W-1:0]          new_sum;
    logic [ettv_pkg::CNT_W:0]            new_cnt;
    logic [ettv_pkg::SUM_W-1:0]          mean_w;
    logic [ettv_pkg::CAL_W-1:0]          pt_cur;
    logic [ettv_pkg::CAL_W-1:0]          pt_hi;
    logic [ettv_pkg::SUM_W-1:0]          pt_cur_ext;
    logic [ettv_pkg::SUM_W-1:0]          pt_hi_ext;
    logic [ettv_pkg::SUM_W-1:0]          seg_diff;
    logic [ettv_pkg::TANK_PROD_W-1:0]    tank_prod;
    logic [ettv_pkg::TDIV_W-1:0]         tank_div;
    logic [ettv_pkg::DIVD_W-1:0]         pct_q;
    logic [ettv_pkg::TENTH_PW-1:0]       tenth_prod;
    logic                                out_free;

    assign ram_rdata = ram_rbits;

    ettv_ram #(
        .WIDTH (ettv_pkg::STATE_W),
        .DEPTH (ettv_pkg::STATE_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ettv_pkg::STATE_AW'(0)),
        .wdata (ram_wdata),
        .raddr (ettv_pkg::STATE_AW'(0)),
        .rdata (ram_rbits)
    );

    ettv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        // accumulate
        new_sum = ram_rdata.sum + ettv_pkg::SUM_W'(time_reg);
        new_cnt = {1'b0, ram_rdata.count} + (ettv_pkg::CNT_W + 1)'(1);

        // table points around the walk index
        mean_w     = prod_reg[ettv_pkg::RECIP_SHIFT +: ettv_pkg::SUM_W];
        pt_cur     = ettv_pkg::cal_point(idx_reg);
        pt_hi      = ettv_pkg::cal_point(idx_reg - ettv_pkg::ROM_AW'(1));
        pt_cur_ext = ettv_pkg::SUM_W'(pt_cur);
        pt_hi_ext  = ettv_pkg::SUM_W'(pt_hi);
        seg_diff   = pt_hi_ext - mean_reg;

        // tank_capacity / 10, never zero
        tank_prod = ettv_pkg::TANK_PROD_W'(tank_reg)
                  * ettv_pkg::TANK_PROD_W'(ettv_pkg::TANK_RECIP);
        tank_div  = tank_prod[ettv_pkg::TANK_RECIP_SHIFT +: ettv_pkg::TDIV_W];
        if (tank_div == '0)
        begin
            tank_div = ettv_pkg::TDIV_W'(1);
        end

        pct_q      = prod_reg[ettv_pkg::RECIP_SHIFT +: ettv_pkg::DIVD_W];
        tenth_prod = ettv_pkg::TENTH_PW'(gal_reg[ettv_pkg::GAL_SHIFT +: ettv_pkg::GAL_FRAC_W])
                   * ettv_pkg::TENTH_PW'(ettv_pkg::TENTH_MUL);
        out_free   = !out_valid_reg || !out_stall;

        state_next     = state_reg;
        time_next      = time_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        mean_next      = mean_reg;
        idx_next       = idx_reg;
        vol_next       = vol_reg;
        part_next      = part_reg;
        lit_next       = lit_reg;
        gal_next       = gal_reg;
        tank_next      = tank_reg;
        out_valid_next = out_valid_reg && out_stall;
        liters_next    = liters_reg;
        galw_next      = galw_reg;
        tenth_next     = tenth_reg;
        pct_next       = pct_reg;
        esum_next      = esum_reg;
        ram_we         = 1'b0;
        ram_wdata      = '0;
        div_req        = '0;

        if (cfg_valid && cfg_ready)
        begin
            tank_next = tank_capacity;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                // the ram reads its one entry every cycle
                if (in_valid && echo_valid)
                begin
                    time_next  = echo_time;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ram_we = 1'b1;
                if (new_cnt >= (ettv_pkg::CNT_W + 1)'(ettv_pkg::AVG_SAMPLES))
                begin
                    // batch complete, clear the stored state
                    sum_next   = new_sum;
                    state_next = S_MEAN;
                end
                else
                begin
                    ram_wdata.sum   = new_sum;
                    ram_wdata.count = new_cnt[ettv_pkg::CNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            S_MEAN:
            begin
                prod_next  = ettv_pkg::PROD_W'(sum_reg)
                           * ettv_pkg::PROD_W'(ettv_pkg::AVG_RECIP);
                state_next = S_WALK0;
            end
            S_WALK0:
            begin
                mean_next = mean_w;
                idx_next  = ettv_pkg::ROM_AW'(1);
                vol_next  = '0;
                part_next = '0;
                if (mean_w >= ettv_pkg::SUM_W'(ettv_pkg::cal_point(ettv_pkg::ROM_AW'(0))))
                begin
                    // at or above the top point: empty tank
                    state_next = S_CONV;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // stop at the last segment, it is extended below its end
                if (idx_reg < ettv_pkg::ROM_AW'(ettv_pkg::CAL_POINTS - 1)
                    && pt_cur_ext > mean_reg)
                begin
                    vol_next = vol_reg + ettv_pkg::LIT_W'(ettv_pkg::LITERS_PER_POINT);
                    idx_next = idx_reg + ettv_pkg::ROM_AW'(1);
                end
                else
                begin
                    state_next = S_INTERP;
                end
            end
            S_INTERP:
            begin
                if (pt_hi > pt_cur && pt_hi_ext > mean_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = ettv_pkg::DIVD_W'(seg_diff[ettv_pkg::CAL_W-1:0])
                                     * ettv_pkg::DIVD_W'(ettv_pkg::LITERS_PER_POINT);
                    div_req.divisor  = pt_hi - pt_cur;
                    state_next       = S_WAIT_I;
                end
                else
                begin
                    // flat segment or mean on the upper point
                    part_next  = '0;
                    state_next = S_CONV;
                end
            end
            S_WAIT_I:
            begin
                if (div_rsp.done)
                begin
                    part_next  = div_rsp.quotient[ettv_pkg::LIT_W-1:0];
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                lit_next   = vol_reg + part_reg;
                state_next = S_GAL;
            end
            S_GAL:
            begin
                gal_next         = ettv_pkg::GAL_PROD_W'(lit_reg)
                                 * ettv_pkg::GAL_PROD_W'(ettv_pkg::GAL_MUL);
                div_req.start    = 1'b1;
                div_req.dividend = ettv_pkg::DIVD_W'(lit_reg)
                                 * ettv_pkg::DIVD_W'(ettv_pkg::PCT_MUL);
                div_req.divisor  = ettv_pkg::DIVS_W'(tank_div);
                state_next       = S_WAIT_P;
            end
            S_WAIT_P:
            begin
                if (div_rsp.done)
                begin
                    prod_next  = ettv_pkg::PROD_W'(div_rsp.quotient)
                               * ettv_pkg::PROD_W'(ettv_pkg::PCT_RECIP);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    liters_next    = lit_reg;
                    galw_next      = gal_reg[ettv_pkg::GAL_SHIFT + ettv_pkg::GAL_FRAC_W
                                             +: ettv_pkg::GALW_W];
                    tenth_next     = tenth_prod[ettv_pkg::GAL_FRAC_W +: ettv_pkg::TENTH_W];
                    if (pct_q > ettv_pkg::DIVD_W'(ettv_pkg::PCT_MAX))
                    begin
                        pct_next = ettv_pkg::PCT_W'(ettv_pkg::PCT_MAX);
                    end
                    else
                    begin
                        pct_next = pct_q[ettv_pkg::PCT_W-1:0];
                    end
                    esum_next      = sum_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            time_reg      <= '0;
            sum_reg       <= '0;
            prod_reg      <= '0;
            mean_reg      <= '0;
            idx_reg       <= '0;
            vol_reg       <= '0;
            part_reg      <= '0;
            lit_reg       <= '0;
            gal_reg       <= '0;
            tank_reg      <= ettv_pkg::TANK_W'(ettv_pkg::TANK_RESET);
            out_valid_reg <= 1'b0;
            liters_reg    <= '0;
            galw_reg      <= '0;
            tenth_reg     <= '0;
            pct_reg       <= '0;
            esum_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            sum_reg       <= sum_next;
            prod_reg      <= prod_next;
            mean_reg      <= mean_next;
            idx_reg       <= idx_next;
            vol_reg       <= vol_next;
            part_reg      <= part_next;
            lit_reg       <= lit_next;
            gal_reg       <= gal_next;
            tank_reg      <= tank_next;
            out_valid_reg <= out_valid_next;
            liters_reg    <= liters_next;
            galw_reg      <= galw_next;
            tenth_reg     <= tenth_next;
            pct_reg       <= pct_next;
            esum_reg      <= esum_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign liters        = liters_reg;
    assign gallons_whole = galw_reg;
    assign gallons_tenth = tenth_reg;
    assign percent_full  = pct_reg;
    assign echo_sum      = esum_reg;

endmodule

FILE: test/tb_top.sv
// testbench for the echo time to tank volume block: directed and random batches against a predictor
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ECHO_W  = ettv_pkg::ECHO_W;
    localparam int SUM_W   = ettv_pkg::SUM_W;
    localparam int TANK_W  = ettv_pkg::TANK_W;
    localparam int LIT_W   = ettv_pkg::LIT_W;
    localparam int GALW_W  = ettv_pkg::GALW_W;
    localparam int TENTH_W = ettv_pkg::TENTH_W;
    localparam int PCT_W   = ettv_pkg::PCT_W;

    // numbers of the calibration and conversion, kept local to the predictor
    localparam int unsigned AVG_COUNT    = 5;
    localparam int unsigned LAST_STEP    = 11;
    localparam int unsigned LITERS_STEP  = 100;
    localparam int unsigned GALLON_MUL   = 541;
    localparam int unsigned GALLON_SHIFT = 6;
    localparam int unsigned FRAC_BITS    = 5;
    localparam int unsigned FRAC_MASK    = 31;
    localparam int unsigned PCT_SCALE    = 50;
    localparam int unsigned PCT_DIVIDE   = 5;
    localparam int unsigned PCT_CEILING  = 127;
    localparam int unsigned TIME_MAX     = 65534;
    localparam int unsigned TANK_MIN     = 10;
    localparam int unsigned TANK_MAX     = 1000;

    // echo time in microseconds at each 100 liter mark, descending
    localparam int unsigned ECHO_AT_STEP [12] = '{
        5960, 5380, 4800, 4240, 3734, 3200, 2684, 2150, 1612, 1068, 536, 4
    };

    // cycles to let the block finish an item that yields no reading
    localparam int SETTLE_CYCLES = 100;
    // far above the slowest correct run
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [LIT_W-1:0]   liters;
        logic [GALW_W-1:0]  gallons_whole;
        logic [TENTH_W-1:0] gallons_tenth;
        logic [PCT_W-1:0]   percent_full;
        logic [SUM_W-1:0]   echo_sum;
    } reading_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // echo items into the block
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              echo_valid = 1'b0;
    logic [ECHO_W-1:0] echo_time  = '0;

    // readings out of the block
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [LIT_W-1:0]   liters;
    logic [GALW_W-1:0]  gallons_whole;
    logic [TENTH_W-1:0] gallons_tenth;
    logic [PCT_W-1:0]   percent_full;
    logic [SUM_W-1:0]   echo_sum;

    // tank size register
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [TANK_W-1:0] tank_capacity = '0;

    // predictor state: its own copy of the batch sum, count and tank size
    logic [SUM_W-1:0]  batch_sum   = '0;
    int unsigned       batch_count = 0;
    logic [TANK_W-1:0] tank_size   = TANK_W'(TANK_MAX);
    reading_t          pending_readings [$];

    // idling: 1 in gap_odds chance of a gap after an item, 0 means none
    int unsigned gap_odds   = 5;
    int unsigned stall_odds = 8;
    int unsigned stall_left = 0;

    // run statistics
    int unsigned items_sent    = 0;
    int unsigned echoes_sent   = 0;
    int unsigned readings_seen = 0;
    int unsigned tanks_tried   = 0;
    int unsigned errors        = 0;
    int unsigned cycle_count   = 0;

    echo_time_to_tank_volume dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .echo_valid    (echo_valid),
        .echo_time     (echo_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .liters        (liters),
        .gallons_whole (gallons_whole),
        .gallons_tenth (gallons_tenth),
        .percent_full  (percent_full),
        .echo_sum      (echo_sum),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .tank_capacity (tank_capacity)
    );

    always #5 clk = ~clk;

    // mean of the batch placed on the calibration curve, then gallons and percent
    function automatic reading_t volume_from_sum(input logic [SUM_W-1:0] sum,
                                                 input logic [TANK_W-1:0] tank);
        int unsigned mean;
        int unsigned vol;
        int unsigned step;
        int unsigned upper;
        int unsigned lower;
        int unsigned part;
        int unsigned gal;
        int unsigned tenths;
        int unsigned pct;
        reading_t    r;
        mean = sum / AVG_COUNT;
        vol  = 0;
        part = 0;
        // at or above the first mark the tank counts as empty
        if (mean < ECHO_AT_STEP[0])
        begin
            step = 1;
            // the walk stops on the last segment, which is extended below its end
            while (step < LAST_STEP && ECHO_AT_STEP[step] > mean)
            begin
                vol  += LITERS_STEP;
                step += 1;
            end
            upper = ECHO_AT_STEP[step - 1];
            lower = ECHO_AT_STEP[step];
            // a segment that does not fall adds nothing
            if (upper > lower && upper > mean)
                part = ((upper - mean) * LITERS_STEP) / (upper - lower);
            vol += part;
        end
        gal    = (vol * GALLON_MUL) >> GALLON_SHIFT;
        tenths = tank / 10;
        if (tenths == 0)
            tenths = 1;
        pct = ((vol * PCT_SCALE) / tenths) / PCT_DIVIDE;
        if (pct > PCT_CEILING)
            pct = PCT_CEILING;
        r.liters        = LIT_W'(vol);
        r.gallons_whole = GALW_W'(gal >> FRAC_BITS);
        r.gallons_tenth = TENTH_W'(((gal & FRAC_MASK) * 10) >> FRAC_BITS);
        r.percent_full  = PCT_W'(pct);
        r.echo_sum      = sum;
        return r;
    endfunction

    // watch accepted items and register writes, keep the predictor in step
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tank_size = tank_capacity;
            if (in_valid && !in_stall)
            begin
                items_sent += 1;
                // no echo: the slot is taken and nothing changes
                if (echo_valid)
                begin
                    echoes_sent += 1;
                    batch_sum    = batch_sum + echo_time;
                    batch_count += 1;
                    if (batch_count == AVG_COUNT)
                    begin
                        pending_readings.push_back(volume_from_sum(batch_sum, tank_size));
                        batch_sum   = '0;
                        batch_count = 0;
                    end
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors += 1;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // compare every accepted reading with the oldest one predicted
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            readings_seen += 1;
            if (pending_readings.size() == 0)
            begin
                errors += 1;
                $display("%0t ns: reading with none expected, expected nothing, got liters %0d sum %0d",
                         $time, liters, echo_sum);
            end
            else
            begin
                want = pending_readings.pop_front();
                check_field("liters", 32'(want.liters), 32'(liters));
                check_field("gallons_whole", 32'(want.gallons_whole), 32'(gallons_whole));
                check_field("gallons_tenth", 32'(want.gallons_tenth), 32'(gallons_tenth));
                check_field("percent_full", 32'(want.percent_full), 32'(percent_full));
                check_field("echo_sum", 32'(want.echo_sum), 32'(echo_sum));
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (stall_odds == 0)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left -= 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, stall_odds - 1) == 0)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // hard stop if the run hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count += 1;
        end
        $display("run timed out after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    // offer one echo item and hold it until taken; valid stays high unless a gap follows
    task automatic send_item(input logic has_echo, input logic [ECHO_W-1:0] usec);
        in_valid   <= 1'b1;
        echo_valid <= has_echo;
        echo_time  <= usec;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // stop sending, wait for every predicted reading, then let stray work finish
    task automatic wait_drained();
        in_valid <= 1'b0;
        // let the last accepted item reach the predictor first
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // the tank size only changes while the block is idle
    task automatic write_tank(input logic [TANK_W-1:0] size);
        wait_drained();
        cfg_valid     <= 1'b1;
        tank_capacity <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tanks_tried += 1;
    endtask

    // five echoes spread around a target mean, some empty slots mixed in
    task automatic send_batch(input int target, input int spread);
        int t;
        for (int k = 0; k < AVG_COUNT; k++)
        begin
            if ($urandom_range(0, 5) == 0)
                send_item(1'b0, ECHO_W'($urandom_range(0, TIME_MAX)));
            t = target + int'($urandom_range(0, 2 * spread)) - spread;
            if (t < 0)
                t = 0;
            if (t > int'(TIME_MAX))
                t = TIME_MAX;
            send_item(1'b1, ECHO_W'(t));
        end
    endtask

    // a batch aimed at a random region of the curve
    task automatic send_random_batch();
        int target;
        int spread;
        case ($urandom_range(0, 5))
            0: target = ECHO_AT_STEP[$urandom_range(0, LAST_STEP)] + int'($urandom_range(0, 6)) - 3;
            1: target = $urandom_range(0, 6200);
            2: target = $urandom_range(0, TIME_MAX);
            3: target = $urandom_range(0, 20);
            4: target = ECHO_AT_STEP[0] + int'($urandom_range(0, 4)) - 2;
            default: target = ECHO_AT_STEP[$urandom_range(0, LAST_STEP)];
        endcase
        case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 3;
            2: spread = 60;
            default: spread = 1500;
        endcase
        send_batch(target, spread);
    endtask

    // extremes of the echo time, the first mark exactly and just below, empty slots
    task automatic test_directed_extremes();
        // all zero: mean below the last mark, full plus the extended segment
        repeat (AVG_COUNT) send_item(1'b1, '0);
        // all at the top of the range: widest sum, empty tank
        repeat (AVG_COUNT) send_item(1'b1, ECHO_W'(TIME_MAX));
        // mean exactly on the first mark, with empty slots carrying extreme times
        send_item(1'b1, ECHO_W'(ECHO_AT_STEP[0]));
        send_item(1'b0, ECHO_W'(TIME_MAX));
        send_item(1'b1, ECHO_W'(ECHO_AT_STEP[0]));
        send_item(1'b0, '0);
        repeat (3) send_item(1'b1, ECHO_W'(ECHO_AT_STEP[0]));
        // one below the first mark: the first segment starts
        repeat (AVG_COUNT) send_item(1'b1, ECHO_W'(ECHO_AT_STEP[0] - 1));
    endtask

    // several tank sizes with the extremes, each with a full-tank batch for saturation
    task automatic test_tank_sizes();
        logic [TANK_W-1:0] sizes [7];
        sizes = '{TANK_W'(TANK_MIN), TANK_W'(TANK_MAX), TANK_W'(TANK_MIN + 1),
                  TANK_W'(TANK_MAX - 1), TANK_W'(100),
                  TANK_W'($urandom_range(TANK_MIN, TANK_MAX)),
                  TANK_W'($urandom_range(TANK_MIN, TANK_MAX))};
        foreach (sizes[s])
        begin
            write_tank(sizes[s]);
            send_batch(0, 0);
            repeat (4) send_random_batch();
        end
    endtask

    // bulk of the run, in chunks with their own idling, drained between chunks
    task automatic test_random_batches();
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            gap_odds   = $urandom_range(0, 2) * 3;
            stall_odds = $urandom_range(0, 2) * 4;
            repeat (20) send_random_batch();
            // sender holds off until every reading is back
            wait_drained();
        end
        gap_odds   = 5;
        stall_odds = 8;
    endtask

    // closing stretch with no idling on either side
    task automatic test_back_to_back();
        write_tank(TANK_W'($urandom_range(TANK_MIN, TANK_MAX)));
        gap_odds   = 0;
        stall_odds = 0;
        repeat (12) send_random_batch();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_tank_sizes();
        test_random_batches();
        test_back_to_back();
        wait_drained();
        if (pending_readings.size() != 0)
        begin
            errors += 1;
            $display("%0t ns: readings left over, expected 0, got %0d",
                     $time, pending_readings.size());
        end
        $display("covered %0d echo slots (%0d with an echo) and %0d readings",
                 items_sent, echoes_sent, readings_seen);
        $display("over %0d tank size writes, %0d mismatches", tanks_tried, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
